// ===== rtl/ipf_pkg.sv =====
`timescale 1ns / 1ps

package ipf_pkg;

    // Default for the longest field handed out; longer fields are cut short.
    localparam int MAX_WIDTH_DEF = 63;

    // Decimal digits of a 32-bit magnitude, and the packed BCD register width.
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int VALUE_W    = 32;
    localparam int DIG_CNT_W  = 4;

    // Longest possible field: sign plus 63 precision zeros and digits together.
    localparam int LEN_W = 7;

    // Conversion kinds.
    localparam logic [1:0] ACT_SDEC  = 2'd0;
    localparam logic [1:0] ACT_UDEC  = 2'd1;
    localparam logic [1:0] ACT_LHEX  = 2'd2;
    localparam logic [1:0] ACT_UHEX  = 2'd3;

    // ASCII codes.
    localparam logic [6:0] CH_NUL     = 7'h00;
    localparam logic [6:0] CH_BLANK   = 7'h20;
    localparam logic [6:0] CH_MINUS   = 7'h2D;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    typedef struct packed {
        logic start;     // begin converting a new magnitude
        logic hex;       // base 16 instead of base 10
        logic suppress;  // zero value with zero precision: no digits at all
        logic shift;     // the top digit was consumed, move the next one up
    } dig_ctrl_t;

    typedef struct packed {
        logic                 done;
        logic [DIG_CNT_W-1:0] nd;    // significant digits, 0 only when suppressed
        logic [3:0]           top;   // most significant remaining digit
    } dig_stat_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] base_ch;
        begin
            base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < DIGIT_TEN)
            begin
                digit_char = CH_ZERO + {3'b000, d};
            end
            else
            begin
                digit_char = base_ch + {3'b000, d - DIGIT_TEN};
            end
        end
    endfunction

endpackage

// ===== rtl/ipf_digits.sv =====
`timescale 1ns / 1ps

// Serial digit generator. Decimal values go through a shift-and-add-3
// converter one bit per cycle; hex values load their nibbles directly.
// Leading zero digits are then shifted out one per cycle, and the digits
// leave from the top of the register one per shift request.
module ipf_digits (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ipf_pkg::dig_ctrl_t             ctrl,
    input  logic [ipf_pkg::VALUE_W-1:0]    mag,
    output ipf_pkg::dig_stat_t             stat
);
    import ipf_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CONV = 2'd1;
    localparam logic [1:0] PH_NORM = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam int BIT_CNT_W = $clog2(VALUE_W);

    logic [1:0]           phase_reg, phase_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIG_CNT_W-1:0] nd_reg, nd_next;
    logic [BCD_W-1:0]     bcd_adj;

    // Add 3 to every BCD digit of 5 or more before the next doubling.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        nd_next    = nd_reg;
        if (ctrl.start)
        begin
            cnt_next = '0;
            bin_next = mag;
            if (ctrl.suppress)
            begin
                nd_next    = '0;
                phase_next = PH_DONE;
            end
            else if (ctrl.hex)
            begin
                nd_next    = DIG_CNT_W'(NUM_DIGITS);
                bcd_next   = {{(BCD_W-VALUE_W){1'b0}}, mag};
                phase_next = PH_NORM;
            end
            else
            begin
                nd_next    = DIG_CNT_W'(NUM_DIGITS);
                bcd_next   = '0;
                phase_next = PH_CONV;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CONV:
                begin
                    bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                    bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                    begin
                        phase_next = PH_NORM;
                    end
                end
                PH_NORM:
                begin
                    if ((bcd_reg[BCD_W-1 -: 4] == 4'd0) && (nd_reg > 4'd1))
                    begin
                        bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                        nd_next  = nd_reg - 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    if (ctrl.shift)
                    begin
                        bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        nd_reg  <= nd_next;
    end

    assign stat.done = (phase_reg == PH_DONE);
    assign stat.nd   = nd_reg;
    assign stat.top  = bcd_reg[BCD_W-1 -: 4];

endmodule

// ===== rtl/integer_printf_formatter_unit.sv =====
`timescale 1ns / 1ps

// Integer printf formatter (%d, %u, %x, %X). Each request on the slave side
// carries one 32-bit value with its field width, optional precision and the
// left-justify and zero-pad flags; the block answers with the formatted ASCII
// characters, one per master-side transfer, in the order leading blanks,
// minus sign, leading zeros, digits, trailing blanks, with tlast on the final
// one. A conversion that produces no character at all still sends a single
// transfer with character code 0, tlast high and the empty flag in tuser.
// Fields longer than MAX_WIDTH characters are cut to MAX_WIDTH. The minus sign
// always precedes zero padding, and zero padding is dropped when left
// justification or a precision is given. One request is in work at a time.
// Decimal conversions pass through the bit-serial binary-to-BCD converter,
// the removal of leading zero digits, the hand-off to planning, the planning
// and sizing states and the output register before the first character
// leaves; hex conversions skip the converter, and a zero value with zero
// precision skips the digit work altogether. After that one character leaves
// per cycle while the master side accepts it, and a new request can be taken
// once the last character is registered, while that character may still wait
// on the master side.
module integer_printf_formatter_unit #(
    parameter int MAX_WIDTH = ipf_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // value[31:0], field_width[37:32], has_precision[38], precision[44:39],
    // left_justify[45], zero_pad[46], zero fill[47]
    input  logic [47:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_code[6:0], position[12:7], zero fill[15:13]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // empty_res[0]
    output logic        m_tuser
);
    import ipf_pkg::*;

    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = (MW_W > LEN_W) ? MW_W : LEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIG  = 3'd1;
    localparam logic [2:0] S_PLAN = 3'd2;
    localparam logic [2:0] S_SIZE = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // Request fields.
    logic [1:0]         in_action;
    logic [VALUE_W-1:0] in_value;
    logic [5:0]         in_width;
    logic               in_hp;
    logic [5:0]         in_prec;
    logic               in_ljust;
    logic               in_zpad;
    logic               in_neg;
    logic               accept;

    assign in_action = s_tuser;
    assign in_value  = s_tdata[31:0];
    assign in_width  = s_tdata[37:32];
    assign in_hp     = s_tdata[38];
    assign in_prec   = s_tdata[44:39];
    assign in_ljust  = s_tdata[45];
    assign in_zpad   = s_tdata[46];
    assign in_neg    = (in_action == ACT_SDEC) && in_value[VALUE_W-1];

    logic [2:0]           state_reg, state_next;
    logic [5:0]           width_reg, width_next;
    logic                 hp_reg, hp_next;
    logic [5:0]           prec_reg, prec_next;
    logic                 ljust_reg, ljust_next;
    logic                 zpad_reg, zpad_next;
    logic                 neg_reg, neg_next;
    logic                 upper_reg, upper_next;
    logic [5:0]           zeros_reg, zeros_next;
    logic [LEN_W-1:0]     body_reg, body_next;
    logic [5:0]           blank_cnt_reg, blank_cnt_next;
    logic                 neg_left_reg, neg_left_next;
    logic [5:0]           zero_cnt_reg, zero_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic [5:0]           trail_cnt_reg, trail_cnt_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [6:0]           out_char_reg, out_char_next;
    logic [5:0]           out_pos_reg, out_pos_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_empty_reg, out_empty_next;

    dig_ctrl_t dig_ctrl;
    dig_stat_t dig_stat;
    logic      dig_shift;
    logic      emit_fire;

    // Planning arithmetic, all on narrow values.
    logic [5:0]       nd_ext;
    logic [LEN_W-1:0] width_ext;
    logic [5:0]       pad_len;
    logic [LEN_W-1:0] field_len;
    logic [CNT_W-1:0] field_ext;
    logic [CNT_W-1:0] cap_len;

    assign accept = s_tvalid && s_tready;
    assign nd_ext = {2'b00, dig_stat.nd};
    assign width_ext = {1'b0, width_reg};
    assign pad_len = (width_ext > body_reg) ? 6'(width_ext - body_reg) : 6'd0;
    assign field_len = (width_ext > body_reg) ? width_ext : body_reg;
    assign field_ext = CNT_W'(field_len);
    assign cap_len = (field_ext > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : field_ext;

    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);

    assign dig_ctrl.start    = accept;
    assign dig_ctrl.hex      = in_action[1];
    assign dig_ctrl.suppress = in_hp && (in_prec == 6'd0) && (in_value == '0);
    assign dig_ctrl.shift    = dig_shift;

    ipf_digits u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dig_ctrl),
        .mag   (in_neg ? (~in_value + 32'd1) : in_value),
        .stat  (dig_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        hp_next        = hp_reg;
        prec_next      = prec_reg;
        ljust_next     = ljust_reg;
        zpad_next      = zpad_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        zeros_next     = zeros_reg;
        body_next      = body_reg;
        blank_cnt_next = blank_cnt_reg;
        neg_left_next  = neg_left_reg;
        zero_cnt_next  = zero_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        trail_cnt_next = trail_cnt_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        dig_shift      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    width_next = in_width;
                    hp_next    = in_hp;
                    prec_next  = in_prec;
                    ljust_next = in_ljust;
                    zpad_next  = in_zpad;
                    neg_next   = in_neg;
                    upper_next = (in_action == ACT_UHEX);
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (dig_stat.done)
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                // Precision zeros, then sign plus zeros plus digits.
                zeros_next = (hp_reg && (prec_reg > nd_ext)) ? (prec_reg - nd_ext) : 6'd0;
                body_next  = LEN_W'(neg_reg) + LEN_W'(zeros_next) + LEN_W'(dig_stat.nd);
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                // Lay out the runs: blanks, sign, zeros, digits, blanks.
                neg_left_next = neg_reg;
                dig_cnt_next  = dig_stat.nd;
                pos_next      = '0;
                total_next    = cap_len;
                if (ljust_reg)
                begin
                    blank_cnt_next = 6'd0;
                    zero_cnt_next  = zeros_reg;
                    trail_cnt_next = pad_len;
                end
                else if (zpad_reg && !hp_reg)
                begin
                    blank_cnt_next = 6'd0;
                    zero_cnt_next  = pad_len;
                    trail_cnt_next = 6'd0;
                end
                else
                begin
                    blank_cnt_next = pad_len;
                    zero_cnt_next  = zeros_reg;
                    trail_cnt_next = 6'd0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg[5:0];
                    if (total_reg == '0)
                    begin
                        out_char_next  = CH_NUL;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_empty_next = 1'b0;
                        out_last_next  = (pos_reg + 1'b1 == total_reg);
                        pos_next       = pos_reg + 1'b1;
                        if (pos_reg + 1'b1 == total_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        priority if (blank_cnt_reg != 6'd0)
                        begin
                            out_char_next  = CH_BLANK;
                            blank_cnt_next = blank_cnt_reg - 1'b1;
                        end
                        else if (neg_left_reg)
                        begin
                            out_char_next = CH_MINUS;
                            neg_left_next = 1'b0;
                        end
                        else if (zero_cnt_reg != 6'd0)
                        begin
                            out_char_next = CH_ZERO;
                            zero_cnt_next = zero_cnt_reg - 1'b1;
                        end
                        else if (dig_cnt_reg != '0)
                        begin
                            out_char_next = digit_char(dig_stat.top, upper_reg);
                            dig_cnt_next  = dig_cnt_reg - 1'b1;
                            dig_shift     = 1'b1;
                        end
                        else
                        begin
                            out_char_next  = CH_BLANK;
                            trail_cnt_next = trail_cnt_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        hp_reg        <= hp_next;
        prec_reg      <= prec_next;
        ljust_reg     <= ljust_next;
        zpad_reg      <= zpad_next;
        neg_reg       <= neg_next;
        upper_reg     <= upper_next;
        zeros_reg     <= zeros_next;
        body_reg      <= body_next;
        blank_cnt_reg <= blank_cnt_next;
        neg_left_reg  <= neg_left_next;
        zero_cnt_reg  <= zero_cnt_next;
        dig_cnt_reg   <= dig_cnt_next;
        trail_cnt_reg <= trail_cnt_next;
        pos_reg       <= pos_next;
        total_reg     <= total_next;
        out_char_reg  <= out_char_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pos_reg, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    // An empty conversion is a single NUL that also closes the conversion.
    ast_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[6:0] == CH_NUL)))
        else $error("empty result without tlast or with a character");

    // Characters are only produced once the digit unit has finished.
    ast_emit_after_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> dig_stat.done)
        else $error("emitting before the digits are ready");

    // The digit count never exceeds what a 32-bit value can need.
    ast_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLAN) |-> (dig_stat.nd <= DIG_CNT_W'(NUM_DIGITS)))
        else $error("digit count out of range");

    // A digit is only taken from the converter while digits remain.
    ast_digit_shift: assert property (@(posedge clk) disable iff (!rst_n)
        dig_shift |-> (dig_cnt_reg != '0))
        else $error("digit shifted with none left");

    // Positions stay inside the truncated field.
    ast_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (CNT_W'(out_pos_reg) < CNT_W'(MAX_WIDTH)))
        else $error("character beyond the maximum field width");

endmodule
